// File: hw/rtl/kmc_pkg.sv
`timescale 1ns / 1ps
// Package for the key matrix two-key combo match unit.
// Holds the request and result structs, register map and status codes.
// No dependencies.
package kmc_pkg;

    localparam int ROW_LINES_DEF  = 8;
    localparam int COL_LINES_DEF  = 8;
    localparam int MAX_COMBOS_DEF = 5;
    localparam int PAIR_REGS      = 5;

    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    localparam logic [2:0] REG_SCAN_BY_COLUMNS = 3'd0;
    localparam logic [2:0] REG_COMBO_COUNT     = 3'd1;
    localparam logic [2:0] REG_COMBO_PAIR_0    = 3'd2;
    localparam logic [2:0] REG_COMBO_PAIR_1    = 3'd3;
    localparam logic [2:0] REG_COMBO_PAIR_2    = 3'd4;
    localparam logic [2:0] REG_COMBO_PAIR_3    = 3'd5;
    localparam logic [2:0] REG_COMBO_PAIR_4    = 3'd6;

    typedef enum logic [1:0] {
        STATUS_MATCH    = 2'd0,
        STATUS_COUNT    = 2'd1,
        STATUS_NO_MATCH = 2'd2
    } kmc_status_t;

    typedef struct packed {
        logic [2:0] line_index;
        logic [7:0] line_bits;
        logic       last_line;
    } kmc_req_t;

    typedef struct packed {
        kmc_status_t status;
        logic [2:0]  combo_index;
        logic [1:0]  pressed_count;
    } kmc_result_t;

    typedef struct packed {
        logic [1:0] total;
        logic [5:0] first_id;
        logic [5:0] second_id;
    } kmc_snap_t;

endpackage

// File: hw/rtl/kmc_accum.sv
`timescale 1ns / 1ps
// Scan accumulator: counts pressed keys per scan and keeps the first two key ids.
// Hands a snapshot to the match stage on the last line. Depends on kmc_pkg.
module kmc_accum
    import kmc_pkg::*;
#(
    parameter int ROW_LINES = ROW_LINES_DEF,
    parameter int COL_LINES = COL_LINES_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      scan_by_columns,
    input  logic      line_valid,
    output logic      line_stall,
    input  kmc_req_t  line_req,
    output logic      snap_valid,
    output kmc_snap_t snap,
    input  logic      snap_take
);

    logic       snap_valid_reg, snap_valid_next;
    kmc_snap_t  snap_reg;
    logic [1:0] total_reg, total_next;
    logic [5:0] first_reg, first_next;
    logic [5:0] second_reg, second_next;

    logic       accept;
    logic       line_ok;
    logic [7:0] bits_masked;
    logic [2:0] bit0, bit1;
    logic       found0, found1;
    logic [1:0] cnt;
    logic [2:0] tsum;
    logic [5:0] id0, id1;

    assign line_stall = snap_valid_reg && !snap_take;
    assign accept     = line_valid && !line_stall;
    assign snap_valid = snap_valid_reg;
    assign snap       = snap_reg;

    always_comb
    begin
        if (scan_by_columns)
        begin
            line_ok = ({1'b0, line_req.line_index} < 4'(COL_LINES));
        end
        else
        begin
            line_ok = ({1'b0, line_req.line_index} < 4'(ROW_LINES));
        end
        for (int i = 0; i < 8; i++)
        begin
            bits_masked[i] = line_ok && line_req.line_bits[i] &&
                             (scan_by_columns ? (i < ROW_LINES) : (i < COL_LINES));
        end
    end

    always_comb
    begin
        bit0   = 3'd0;
        bit1   = 3'd0;
        found0 = 1'b0;
        found1 = 1'b0;
        cnt    = 2'd0;
        for (int i = 0; i < 8; i++)
        begin
            if (bits_masked[i])
            begin
                if (!found0)
                begin
                    bit0   = 3'(i);
                    found0 = 1'b1;
                end
                else if (!found1)
                begin
                    bit1   = 3'(i);
                    found1 = 1'b1;
                end
                if (cnt != 2'd3)
                begin
                    cnt = cnt + 2'd1;
                end
            end
        end
    end

    always_comb
    begin
        if (scan_by_columns)
        begin
            id0 = {line_req.line_index, bit0};
            id1 = {line_req.line_index, bit1};
        end
        else
        begin
            id0 = {bit0, line_req.line_index};
            id1 = {bit1, line_req.line_index};
        end

        tsum        = {1'b0, total_reg} + {1'b0, cnt};
        total_next  = (tsum > 3'd3) ? 2'd3 : tsum[1:0];
        first_next  = first_reg;
        second_next = second_reg;
        if (total_reg == 2'd0 && cnt != 2'd0)
        begin
            first_next = id0;
        end
        if (total_reg == 2'd0 && cnt >= 2'd2)
        begin
            second_next = id1;
        end
        else if (total_reg == 2'd1 && cnt != 2'd0)
        begin
            second_next = id0;
        end

        snap_valid_next = (accept && line_req.last_line) || (snap_valid_reg && !snap_take);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg      <= 2'd0;
            first_reg      <= 6'd0;
            second_reg     <= 6'd0;
            snap_valid_reg <= 1'b0;
        end
        else
        begin
            snap_valid_reg <= snap_valid_next;
            if (accept)
            begin
                if (line_req.last_line)
                begin
                    total_reg  <= 2'd0;
                    first_reg  <= 6'd0;
                    second_reg <= 6'd0;
                end
                else
                begin
                    total_reg  <= total_next;
                    first_reg  <= first_next;
                    second_reg <= second_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && line_req.last_line)
        begin
            snap_reg.total     <= total_next;
            snap_reg.first_id  <= first_next;
            snap_reg.second_id <= second_next;
        end
    end

endmodule

// File: hw/rtl/kmc_pair_lane.sv
`timescale 1ns / 1ps
// One combo lane: compares a configured unordered key pair against the captured pair.
// Depends on kmc_pkg.
module kmc_pair_lane
    import kmc_pkg::*;
(
    input  logic        enable,
    input  logic [11:0] pair,
    input  kmc_snap_t   snap,
    output logic        hit
);

    logic [5:0] key_a;
    logic [5:0] key_b;

    assign key_a = pair[11:6];
    assign key_b = pair[5:0];

    assign hit = enable &&
                 ((key_a == snap.first_id && key_b == snap.second_id) ||
                  (key_a == snap.second_id && key_b == snap.first_id));

endmodule

// File: hw/rtl/kmc_merge.sv
`timescale 1ns / 1ps
// Merge stage: picks the lowest hitting lane, builds the result and holds it
// in the output register. Depends on kmc_pkg.
module kmc_merge
    import kmc_pkg::*;
#(
    parameter int MAX_COMBOS = MAX_COMBOS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  snap_valid,
    input  kmc_snap_t             snap,
    input  logic [MAX_COMBOS-1:0] hits,
    output logic                  snap_take,
    output logic                  result_valid,
    input  logic                  result_stall,
    output kmc_result_t           result
);

    logic        out_valid_reg, out_valid_next;
    kmc_result_t out_reg, out_next;
    logic [2:0]  hit_index;

    assign snap_take    = snap_valid && (!out_valid_reg || !result_stall);
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    always_comb
    begin
        hit_index = 3'd0;
        for (int i = MAX_COMBOS - 1; i >= 0; i--)
        begin
            if (hits[i])
            begin
                hit_index = 3'(i);
            end
        end

        out_next.pressed_count = snap.total;
        out_next.combo_index   = 3'd0;
        if (snap.total != 2'd2)
        begin
            out_next.status = STATUS_COUNT;
        end
        else if (|hits)
        begin
            out_next.status      = STATUS_MATCH;
            out_next.combo_index = hit_index;
        end
        else
        begin
            out_next.status = STATUS_NO_MATCH;
        end

        out_valid_next = snap_take || (out_valid_reg && result_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (snap_take)
        begin
            out_reg <= out_next;
        end
    end

endmodule

// File: hw/rtl/key_matrix_two_key_combo_match_unit.sv
`timescale 1ns / 1ps
// Top level of the key matrix two-key combo match unit: register file,
// scan accumulator, combo lanes and merge stage. Depends on kmc_pkg.
//
//   Channel   Direction  Handshake                 Payload
//   line      in         line_valid / line_stall   line_req (kmc_req_t)
//   result    out        result_valid / result_stall result (kmc_result_t)
//   config    in         APB psel / penable        paddr, pwdata, prdata
//
// One line request is taken every cycle while line_stall is low. A last-line request
// is registered in the accumulator snapshot, then in the merge output register.
// Reset clears the scan state, the pipeline valids and the configuration registers.
// A stalled result holds in the output register; the next last-line request
// then waits as the accumulator snapshot, and while it waits every line request stalls.
module key_matrix_two_key_combo_match_unit
    import kmc_pkg::*;
#(
    parameter int ROW_LINES  = ROW_LINES_DEF,
    parameter int COL_LINES  = COL_LINES_DEF,
    parameter int MAX_COMBOS = MAX_COMBOS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  line_valid,
    output logic                  line_stall,
    input  kmc_req_t              line_req,
    output logic                  result_valid,
    input  logic                  result_stall,
    output kmc_result_t           result
);

    logic        scan_by_columns_reg;
    logic [2:0]  combo_count_reg;
    logic [11:0] combo_pair_reg [PAIR_REGS];

    logic                  cfg_write;
    logic [2:0]            cfg_index;
    logic                  snap_valid;
    kmc_snap_t             snap;
    logic                  snap_take;
    logic [MAX_COMBOS-1:0] hits;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_by_columns_reg <= 1'b0;
            combo_count_reg     <= 3'd0;
            for (int i = 0; i < PAIR_REGS; i++)
            begin
                combo_pair_reg[i] <= 12'd0;
            end
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_SCAN_BY_COLUMNS: scan_by_columns_reg <= pwdata[0];
                REG_COMBO_COUNT:     combo_count_reg     <= pwdata[2:0];
                REG_COMBO_PAIR_0:    combo_pair_reg[0]   <= pwdata[11:0];
                REG_COMBO_PAIR_1:    combo_pair_reg[1]   <= pwdata[11:0];
                REG_COMBO_PAIR_2:    combo_pair_reg[2]   <= pwdata[11:0];
                REG_COMBO_PAIR_3:    combo_pair_reg[3]   <= pwdata[11:0];
                REG_COMBO_PAIR_4:    combo_pair_reg[4]   <= pwdata[11:0];
                default:             ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_index)
            REG_SCAN_BY_COLUMNS: prdata = {31'd0, scan_by_columns_reg};
            REG_COMBO_COUNT:     prdata = {29'd0, combo_count_reg};
            REG_COMBO_PAIR_0:    prdata = {20'd0, combo_pair_reg[0]};
            REG_COMBO_PAIR_1:    prdata = {20'd0, combo_pair_reg[1]};
            REG_COMBO_PAIR_2:    prdata = {20'd0, combo_pair_reg[2]};
            REG_COMBO_PAIR_3:    prdata = {20'd0, combo_pair_reg[3]};
            REG_COMBO_PAIR_4:    prdata = {20'd0, combo_pair_reg[4]};
            default:             prdata = '0;
        endcase
    end

    kmc_accum #(
        .ROW_LINES (ROW_LINES),
        .COL_LINES (COL_LINES)
    ) u_accum (
        .clk             (clk),
        .rst_n           (rst_n),
        .scan_by_columns (scan_by_columns_reg),
        .line_valid      (line_valid),
        .line_stall      (line_stall),
        .line_req        (line_req),
        .snap_valid      (snap_valid),
        .snap            (snap),
        .snap_take       (snap_take)
    );

    for (genvar g = 0; g < MAX_COMBOS; g++)
    begin : g_lane
        kmc_pair_lane u_lane (
            .enable (combo_count_reg > 3'(g)),
            .pair   (combo_pair_reg[g]),
            .snap   (snap),
            .hit    (hits[g])
        );
    end

    kmc_merge #(
        .MAX_COMBOS (MAX_COMBOS)
    ) u_merge (
        .clk          (clk),
        .rst_n        (rst_n),
        .snap_valid   (snap_valid),
        .snap         (snap),
        .hits         (hits),
        .snap_take    (snap_take),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

// File: hw/rtl/kmc_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the key matrix two-key combo match unit, with its bind.
// Depends on kmc_pkg.
module kmc_checker
    import kmc_pkg::*;
#(
    parameter int MAX_COMBOS = MAX_COMBOS_DEF
)
(
    input logic        clk,
    input logic        rst_n,
    input logic        result_valid,
    input logic        result_stall,
    input kmc_result_t result
);

    // A result that waits under stall must not change or vanish.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("stalled result changed");

    // Any outcome other than a count error implies exactly two keys.
    a_two_keys: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.status != STATUS_COUNT |-> result.pressed_count == 2'd2)
        else $error("pair outcome without exactly two keys");

    // The combo index is zero unless a combo matched.
    a_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.status != STATUS_MATCH |-> result.combo_index == 3'd0)
        else $error("combo index set without a match");

    // A matched combo index names an existing lane.
    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.status == STATUS_MATCH |->
            result.combo_index < 3'(MAX_COMBOS))
        else $error("combo index beyond the lanes");

endmodule

bind key_matrix_two_key_combo_match_unit kmc_checker #(
    .MAX_COMBOS (MAX_COMBOS)
) u_kmc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

// File: dv/testbench.sv
`timescale 1ns / 1ps
// Testbench for the key matrix two-key combo match unit: random and directed scans,
// a scoreboard that predicts each scan result, random line gaps and result stalls.
// Depends on kmc_pkg and key_matrix_two_key_combo_match_unit.
module testbench;
    import kmc_pkg::*;

    localparam int QUIET_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 8;
    localparam int ITEM_GOAL    = 1900;
    localparam int PHASE_ITEMS  = 240;
    localparam int HOLD_CYCLES  = 300;

    class combo_scoreboard;
        logic        scan_by_columns;
        logic [2:0]  combo_count;
        logic [11:0] combo_pair [PAIR_REGS];
        logic [1:0]  key_total;
        logic [5:0]  first_id;
        logic [5:0]  second_id;
        kmc_result_t expected_q [$];
        int unsigned errors;

        function new();
            scan_by_columns = 1'b0;
            combo_count = '0;
            foreach (combo_pair[i])
                combo_pair[i] = '0;
            key_total = '0;
            first_id = '0;
            second_id = '0;
            errors = 0;
        endfunction

        function void set_register(logic [2:0] idx, logic [31:0] value);
            case (idx)
                REG_SCAN_BY_COLUMNS: scan_by_columns = value[0];
                REG_COMBO_COUNT:     combo_count = value[2:0];
                default:
                begin
                    if (idx >= REG_COMBO_PAIR_0 && idx <= REG_COMBO_PAIR_4)
                        combo_pair[idx - REG_COMBO_PAIR_0] = value[11:0];
                end
            endcase
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_request(kmc_req_t req);
            int unsigned scan_lines;
            int unsigned read_lines;
            int unsigned used;
            logic [5:0]  id;
            logic [5:0]  key_a;
            logic [5:0]  key_b;
            kmc_result_t scan_result;
            scan_lines = scan_by_columns ? COL_LINES_DEF : ROW_LINES_DEF;
            read_lines = scan_by_columns ? ROW_LINES_DEF : COL_LINES_DEF;
            if (req.line_index < scan_lines)
            begin
                for (int i = 0; i < read_lines && i < 8; i++)
                begin
                    if (req.line_bits[i])
                    begin
                        id = scan_by_columns ? {req.line_index, i[2:0]}
                                             : {i[2:0], req.line_index};
                        if (key_total == 2'd0)
                            first_id = id;
                        else if (key_total == 2'd1)
                            second_id = id;
                        if (key_total != 2'd3)
                            key_total = key_total + 2'd1;
                    end
                end
            end
            if (req.last_line)
            begin
                scan_result.status = STATUS_COUNT;
                scan_result.combo_index = '0;
                scan_result.pressed_count = key_total;
                if (key_total == 2'd2)
                begin
                    used = (combo_count > MAX_COMBOS_DEF) ? MAX_COMBOS_DEF : combo_count;
                    scan_result.status = STATUS_NO_MATCH;
                    for (int i = 0; i < used; i++)
                    begin
                        key_a = combo_pair[i][11:6];
                        key_b = combo_pair[i][5:0];
                        if ((key_a == first_id && key_b == second_id) ||
                            (key_a == second_id && key_b == first_id))
                        begin
                            scan_result.status = STATUS_MATCH;
                            scan_result.combo_index = i[2:0];
                            break;
                        end
                    end
                end
                expected_q.push_back(scan_result);
                key_total = '0;
                first_id = '0;
                second_id = '0;
            end
        endfunction

        function void check_result(kmc_result_t got);
            kmc_result_t want;
            if (expected_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result status %0d index %0d count %0d",
                         $time, got.status, got.combo_index, got.pressed_count);
            end
            else
            begin
                want = expected_q.pop_front();
                if (got.status != want.status)
                begin
                    errors++;
                    $display("%0t: status expected %0d, got %0d",
                             $time, want.status, got.status);
                end
                if (got.combo_index != want.combo_index)
                begin
                    errors++;
                    $display("%0t: combo_index expected %0d, got %0d",
                             $time, want.combo_index, got.combo_index);
                end
                if (got.pressed_count != want.pressed_count)
                begin
                    errors++;
                    $display("%0t: pressed_count expected %0d, got %0d",
                             $time, want.pressed_count, got.pressed_count);
                end
            end
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  line_valid = 1'b0;
    logic                  line_stall;
    kmc_req_t              line_req = '0;
    logic                  result_valid;
    logic                  result_stall = 1'b0;
    kmc_result_t           result;

    combo_scoreboard sb = new();
    int unsigned     sent_count = 0;
    int unsigned     quiet_cycles = 0;
    bit              hold_request = 1'b0;

    key_matrix_two_key_combo_match_unit uut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .line_valid   (line_valid),
        .line_stall   (line_stall),
        .line_req     (line_req),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        if (rst_n && line_valid && !line_stall)
            sb.note_request(line_req);
        if (rst_n && result_valid && !result_stall)
            sb.check_result(result);
        if (!rst_n || (line_valid && !line_stall) || (result_valid && !result_stall) ||
            (psel && penable))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // The result side stalls in runs of random length; one long hold-off is taken on
    // request so that the unit fills up and stalls the line channel.
    initial
    begin
        int unsigned pick;
        int unsigned span;
        logic        stall_value;
        forever
        begin
            pick = $urandom_range(0, 99);
            if (hold_request)
            begin
                hold_request = 1'b0;
                stall_value = 1'b1;
                span = HOLD_CYCLES;
            end
            else if (pick < 45)
            begin
                stall_value = 1'b0;
                span = $urandom_range(1, 24);
            end
            else if (pick < 92)
            begin
                stall_value = 1'b1;
                span = $urandom_range(1, 3);
            end
            else
            begin
                stall_value = 1'b1;
                span = $urandom_range(10, 40);
            end
            result_stall <= stall_value;
            repeat (span) @(posedge clk);
        end
    end

    function automatic kmc_req_t make_request(logic [2:0] line, logic [7:0] bits, logic last);
        kmc_req_t req;
        req.line_index = line;
        req.line_bits = bits;
        req.last_line = last;
        return req;
    endfunction

    function automatic int unsigned random_gap();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return 0;
        else if (pick < 85)
            return $urandom_range(1, 3);
        else if (pick < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    task automatic send_request(kmc_req_t req, int unsigned gap);
        line_req <= req;
        line_valid <= 1'b1;
        @(posedge clk);
        while (line_stall)
            @(posedge clk);
        sent_count++;
        if (gap != 0)
        begin
            line_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic apb_write(logic [2:0] idx, logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sb.set_register(idx, value);
        @(posedge clk);
    endtask

    task automatic drain_results();
        line_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic run_random_scan(bit no_gaps);
        logic [7:0]  line_map [8];
        logic [5:0]  key_ids [$];
        logic [11:0] pair;
        logic [2:0]  line_no;
        logic [2:0]  bit_no;
        kmc_req_t    scan_q [$];
        kmc_req_t    req;
        int unsigned pick;
        int unsigned keys;
        int unsigned j;
        pick = $urandom_range(0, 99);
        foreach (line_map[i])
            line_map[i] = '0;
        if (pick < 10)
        begin
            keys = $urandom_range(1, 4);
            repeat (keys)
            begin
                req.line_index = 3'($urandom_range(0, 7));
                req.line_bits = 8'($urandom_range(0, 255));
                req.last_line = 1'b0;
                scan_q.push_back(req);
            end
        end
        else
        begin
            if (pick < 55)
            begin
                pair = sb.combo_pair[$urandom_range(0, PAIR_REGS - 1)];
                key_ids.push_back(pair[11:6]);
                key_ids.push_back(pair[5:0]);
            end
            else if (pick < 70)
                keys = 2;
            else if (pick < 78)
                keys = 0;
            else if (pick < 88)
                keys = 1;
            else
                keys = $urandom_range(3, 6);
            if (pick >= 55)
                repeat (keys) key_ids.push_back(6'($urandom_range(0, 63)));
            foreach (key_ids[k])
            begin
                line_no = sb.scan_by_columns ? key_ids[k][5:3] : key_ids[k][2:0];
                bit_no = sb.scan_by_columns ? key_ids[k][2:0] : key_ids[k][5:3];
                if (line_map[line_no][bit_no])
                    scan_q.push_back(make_request(line_no, 8'd1 << bit_no, 1'b0));
                else
                    line_map[line_no][bit_no] = 1'b1;
            end
            keys = $urandom_range(0, 1);
            for (int i = 0; i < 8; i++)
            begin
                if (keys == 1 || line_map[i] != '0)
                    scan_q.push_back(make_request(i[2:0], line_map[i], 1'b0));
            end
            if (scan_q.size() == 0)
                scan_q.push_back(make_request(3'($urandom_range(0, 7)), 8'h00, 1'b0));
            if ($urandom_range(0, 19) == 0)
                scan_q.push_back(scan_q[$urandom_range(0, scan_q.size() - 1)]);
        end
        for (int k = scan_q.size() - 1; k > 0; k--)
        begin
            j = $urandom_range(0, k);
            req = scan_q[k];
            scan_q[k] = scan_q[j];
            scan_q[j] = req;
        end
        scan_q[scan_q.size() - 1].last_line = 1'b1;
        foreach (scan_q[k])
            send_request(scan_q[k], no_gaps ? 0 : random_gap());
    endtask

    initial
    begin
        int unsigned phase_end;
        logic [5:0]  key_a;
        logic [5:0]  key_b;
        logic [2:0]  count_value;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: no combos in use.
        send_request(make_request(3'd0, 8'hFF, 1'b1), random_gap());
        send_request(make_request(3'd7, 8'h00, 1'b1), random_gap());
        send_request(make_request(3'd2, 8'h01, 1'b0), 0);
        send_request(make_request(3'd5, 8'h80, 1'b1), 0);
        drain_results();

        apb_write(REG_SCAN_BY_COLUMNS, 32'd0);
        apb_write(REG_COMBO_COUNT, 32'd5);
        apb_write(REG_COMBO_PAIR_0, {20'd0, 6'd0, 6'd63});
        apb_write(REG_COMBO_PAIR_1, {20'd0, 6'd9, 6'd9});
        apb_write(REG_COMBO_PAIR_2, 32'h0000_0FFF);
        apb_write(REG_COMBO_PAIR_3, {20'd0, 6'd63, 6'd0});
        apb_write(REG_COMBO_PAIR_4, {20'd0, 6'd20, 6'd35});
        send_request(make_request(3'd0, 8'h01, 1'b0), 0);
        send_request(make_request(3'd7, 8'h80, 1'b1), random_gap());
        send_request(make_request(3'd7, 8'h80, 1'b0), 0);
        send_request(make_request(3'd0, 8'h01, 1'b1), 0);
        send_request(make_request(3'd1, 8'h02, 1'b0), random_gap());
        send_request(make_request(3'd1, 8'h02, 1'b1), 0);
        send_request(make_request(3'd7, 8'h80, 1'b0), 0);
        send_request(make_request(3'd7, 8'h80, 1'b1), 0);
        send_request(make_request(3'd3, 8'h18, 1'b1), 0);
        send_request(make_request(3'd4, 8'h07, 1'b1), random_gap());
        drain_results();

        // Column scan with a combo count above the number of pair registers.
        apb_write(REG_SCAN_BY_COLUMNS, 32'd1);
        apb_write(REG_COMBO_COUNT, 32'd7);
        apb_write(REG_COMBO_PAIR_3, {20'd0, 6'd1, 6'd2});
        apb_write(REG_COMBO_PAIR_4, {20'd0, 6'd42, 6'd54});
        send_request(make_request(3'd5, 8'h04, 1'b0), 0);
        send_request(make_request(3'd6, 8'h40, 1'b1), 0);
        send_request(make_request(3'd6, 8'h40, 1'b0), random_gap());
        send_request(make_request(3'd5, 8'h04, 1'b1), 0);
        drain_results();

        apb_write(REG_COMBO_COUNT, 32'd4);
        send_request(make_request(3'd5, 8'h04, 1'b0), 0);
        send_request(make_request(3'd6, 8'h40, 1'b1), 0);

        for (int phase = 0; sent_count < ITEM_GOAL; phase++)
        begin
            drain_results();
            apb_write(REG_SCAN_BY_COLUMNS,
                      (phase < 2) ? {31'd0, phase[0]} : 32'($urandom_range(0, 1)));
            if (phase == 0)
                count_value = 3'd5;
            else if (phase == 1)
                count_value = 3'd0;
            else if (phase == 2)
                count_value = 3'd7;
            else
                count_value = 3'($urandom_range(0, 7));
            apb_write(REG_COMBO_COUNT, {29'd0, count_value});
            for (int i = 0; i < PAIR_REGS; i++)
            begin
                key_a = 6'($urandom_range(0, 63));
                key_b = ($urandom_range(0, 4) == 0) ? key_a : 6'($urandom_range(0, 63));
                apb_write(REG_COMBO_PAIR_0 + i[2:0], {20'd0, key_a, key_b});
            end
            if (phase == 1)
                hold_request = 1'b1;
            phase_end = sent_count + PHASE_ITEMS;
            while (sent_count < phase_end && sent_count < ITEM_GOAL)
                run_random_scan(phase == 1 || $urandom_range(0, 3) == 0);
        end

        drain_results();
        if (sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// File: key_matrix_two_key_combo_match_unit.f
hw/rtl/kmc_pkg.sv
hw/rtl/kmc_accum.sv
hw/rtl/kmc_pair_lane.sv
hw/rtl/kmc_merge.sv
hw/rtl/key_matrix_two_key_combo_match_unit.sv
hw/rtl/kmc_checker.sv
dv/testbench.sv
